### hdl/ugcs_pkg.sv
package ugcs_pkg;

  // Field widths fixed by the interface
  localparam int unsigned DELAY_W = 23;
  localparam int unsigned SWEEP_W = 14;
  localparam int unsigned WAIT_W  = 11;
  localparam int unsigned LEN_W   = 5;
  localparam int unsigned CFG_W   = 23;

  // Campaign phases
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_READY   = 2'd1,
    PH_RESP    = 2'd2,
    PH_RECYCLE = 2'd3
  } phase_t;

  // Request codes carried by an input word
  localparam logic [2:0] REQ_START  = 3'd0;
  localparam logic [2:0] REQ_TICK   = 3'd1;
  localparam logic [2:0] REQ_CHAR   = 3'd2;
  localparam logic [2:0] REQ_IDLE   = 3'd3;
  localparam logic [2:0] REQ_BUTTON = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_ARM     = 2'd0;
  localparam logic [1:0] KIND_REPORT  = 2'd1;
  localparam logic [1:0] KIND_STOPPED = 2'd2;

  // Final status codes
  localparam logic [2:0] ST_RUNNING   = 3'd0;
  localparam logic [2:0] ST_GLITCHED  = 3'd1;
  localparam logic [2:0] ST_TIMEOUT   = 3'd2;
  localparam logic [2:0] ST_CANCELLED = 3'd3;
  localparam logic [2:0] ST_EXHAUSTED = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_TRIGGER_CHAR = 3'd0;
  localparam logic [2:0] CFG_DELAY_MIN    = 3'd1;
  localparam logic [2:0] CFG_DELAY_WANDER = 3'd2;
  localparam logic [2:0] CFG_PULSE_WIDTH  = 3'd3;
  localparam logic [2:0] CFG_RECYCLE_MS   = 3'd4;
  localparam logic [2:0] CFG_REJECT_CHAR  = 3'd5;
  localparam logic [2:0] CFG_RETRY_LIMIT  = 3'd6;
  localparam logic [2:0] CFG_READY_OFF    = 3'd7;

  // Special characters
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  // Number of runs of one bits in a character.
  function automatic logic [2:0] runs_of_ones(input logic [7:0] v);
    logic [2:0] n;
    logic       prev;
    n    = 3'd0;
    prev = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (v[i] && !prev) begin
        n = n + 3'd1;
      end
      prev = v[i];
    end
    return n;
  endfunction

endpackage

### hdl/uart_glitch_campaign_sequencer.sv
// An accepted word is held in the input register, and its result (if any) is loaded
// into the output register when the word leaves the input stage.
// Throughput: one word per cycle; the input stalls only while a result is held in the
// output register and a word waits in the input stage.
// Reset: synchronous, active low; configuration returns to its defaults, the
// campaign goes idle and both pipeline stages empty.
module uart_glitch_campaign_sequencer #(
  parameter int unsigned RESPONSE_LIMIT      = 20,
  parameter int unsigned READY_TIMEOUT_TICKS = 1000
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   in_req_type,
  input  logic [7:0]                   in_rx_char,
  input  logic                         in_ready_level,
  // Result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_result_kind,
  output logic [7:0]                   out_tx_char,
  output logic [ugcs_pkg::DELAY_W-1:0] out_pulse_on_time,
  output logic [2:0]                   out_edge_count,
  output logic [ugcs_pkg::DELAY_W-1:0] out_attempt_delay,
  output logic [ugcs_pkg::SWEEP_W-1:0] out_sweep_index,
  output logic [ugcs_pkg::LEN_W-1:0]   out_response_length,
  output logic                         out_fail_seen,
  output logic [2:0]                   out_final_status,
  // Configuration port
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [ugcs_pkg::CFG_W-1:0]   cfg_data
);

  localparam logic [ugcs_pkg::LEN_W-1:0]  LEN_LAST = ugcs_pkg::LEN_W'(RESPONSE_LIMIT - 1);
  localparam logic [ugcs_pkg::WAIT_W-1:0] TIMEOUT  = ugcs_pkg::WAIT_W'(READY_TIMEOUT_TICKS);

  // Configuration registers
  logic [7:0]                   trigger_char_r;
  logic [ugcs_pkg::DELAY_W-1:0] delay_min_r;
  logic [5:0]                   delay_wander_r;
  logic [ugcs_pkg::DELAY_W-1:0] pulse_width_r;
  logic [9:0]                   recycle_ms_r;
  logic [7:0]                   reject_char_r;
  logic [ugcs_pkg::SWEEP_W-1:0] retry_limit_r;
  logic                         ready_off_r;

  // Input stage
  logic       s1_valid_r;
  logic [2:0] s1_req_r;
  logic [7:0] s1_char_r;
  logic       s1_ready_r;

  // Campaign state
  ugcs_pkg::phase_t             phase_r, phase_nxt;
  logic [ugcs_pkg::DELAY_W-1:0] delay_r, delay_nxt;
  logic [ugcs_pkg::SWEEP_W-1:0] sweep_r, sweep_nxt;
  logic [ugcs_pkg::WAIT_W-1:0]  wait_r, wait_nxt;
  logic [ugcs_pkg::LEN_W-1:0]   len_r, len_nxt;
  logic                         fail_r, fail_nxt;
  logic                         nul_r, nul_nxt;
  logic                         any_r, any_nxt;

  // Output register
  logic                         out_valid_r, out_valid_nxt;
  logic [1:0]                   kind_r, kind_nxt;
  logic [7:0]                   tx_r, tx_nxt;
  logic [ugcs_pkg::DELAY_W-1:0] pulse_r, pulse_nxt;
  logic [2:0]                   edges_r, edges_nxt;
  logic [ugcs_pkg::DELAY_W-1:0] gdelay_r, gdelay_nxt;
  logic [ugcs_pkg::SWEEP_W-1:0] gsweep_r, gsweep_nxt;
  logic [ugcs_pkg::LEN_W-1:0]   rlen_r, rlen_nxt;
  logic                         rfail_r, rfail_nxt;
  logic [2:0]                   status_r, status_nxt;

  logic advance;
  logic fire;
  logic has_result;

  // Decision flags for the current word
  logic       do_arm, do_check, do_finish, do_stop;
  logic [2:0] stop_status;

  // Helper values
  logic [ugcs_pkg::WAIT_W-1:0]  wait_plus;
  logic [ugcs_pkg::LEN_W-1:0]   len_plus;
  logic [ugcs_pkg::DELAY_W:0]   delay_plus;
  logic [ugcs_pkg::DELAY_W:0]   delay_top;
  logic [ugcs_pkg::SWEEP_W-1:0] sweep_plus;
  logic                         is_crlf;
  logic [2:0]                   fin_status;

  // The input stage moves on whenever the output register is free or being taken.
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  assign wait_plus  = wait_r + ugcs_pkg::WAIT_W'(1);
  assign len_plus   = len_r + ugcs_pkg::LEN_W'(1);
  assign delay_plus = {1'b0, delay_r} + (ugcs_pkg::DELAY_W+1)'(1);
  assign delay_top  = {1'b0, delay_min_r} + (ugcs_pkg::DELAY_W+1)'(delay_wander_r);
  assign sweep_plus = sweep_r + ugcs_pkg::SWEEP_W'(1);
  assign is_crlf    = (s1_char_r == ugcs_pkg::CHAR_CR) || (s1_char_r == ugcs_pkg::CHAR_LF);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_char_r <= 8'd13;
      delay_min_r    <= ugcs_pkg::DELAY_W'(1);
      delay_wander_r <= 6'd1;
      pulse_width_r  <= ugcs_pkg::DELAY_W'(1);
      recycle_ms_r   <= 10'd10;
      reject_char_r  <= 8'd35;
      retry_limit_r  <= ugcs_pkg::SWEEP_W'(100);
      ready_off_r    <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ugcs_pkg::CFG_TRIGGER_CHAR: trigger_char_r <= cfg_data[7:0];
        ugcs_pkg::CFG_DELAY_MIN:    delay_min_r    <= cfg_data[ugcs_pkg::DELAY_W-1:0];
        ugcs_pkg::CFG_DELAY_WANDER: delay_wander_r <= cfg_data[5:0];
        ugcs_pkg::CFG_PULSE_WIDTH:  pulse_width_r  <= cfg_data[ugcs_pkg::DELAY_W-1:0];
        ugcs_pkg::CFG_RECYCLE_MS:   recycle_ms_r   <= cfg_data[9:0];
        ugcs_pkg::CFG_REJECT_CHAR:  reject_char_r  <= cfg_data[7:0];
        ugcs_pkg::CFG_RETRY_LIMIT:  retry_limit_r  <= cfg_data[ugcs_pkg::SWEEP_W-1:0];
        ugcs_pkg::CFG_READY_OFF:    ready_off_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_req_r   <= in_req_type;
      s1_char_r  <= in_rx_char;
      s1_ready_r <= in_ready_level;
    end
  end

  // Decide what the word in the input stage does to the campaign.
  always_comb begin
    do_arm      = 1'b0;
    do_check    = 1'b0;
    do_finish   = 1'b0;
    do_stop     = 1'b0;
    stop_status = ugcs_pkg::ST_CANCELLED;
    delay_nxt   = delay_r;
    sweep_nxt   = sweep_r;
    wait_nxt    = wait_r;
    len_nxt     = len_r;
    fail_nxt    = fail_r;
    nul_nxt     = nul_r;
    any_nxt     = any_r;
    if (fire) begin
      if (s1_req_r == ugcs_pkg::REQ_BUTTON) begin
        do_stop = (phase_r != ugcs_pkg::PH_IDLE);
      end else if (s1_req_r == ugcs_pkg::REQ_START) begin
        if (phase_r == ugcs_pkg::PH_IDLE) begin
          delay_nxt = delay_min_r;
          sweep_nxt = '0;
          do_check  = 1'b1;
        end
      end else if (s1_req_r == ugcs_pkg::REQ_TICK || s1_req_r == ugcs_pkg::REQ_CHAR ||
                   s1_req_r == ugcs_pkg::REQ_IDLE) begin
        unique case (phase_r)
          ugcs_pkg::PH_READY: begin
            if (ready_off_r || s1_ready_r) begin
              do_arm = 1'b1;
            end else if (s1_req_r == ugcs_pkg::REQ_TICK) begin
              wait_nxt = wait_plus;
              if (wait_plus > TIMEOUT) begin
                do_stop     = 1'b1;
                stop_status = ugcs_pkg::ST_TIMEOUT;
              end
            end
          end
          ugcs_pkg::PH_RECYCLE: begin
            if (s1_req_r == ugcs_pkg::REQ_TICK) begin
              wait_nxt = wait_plus;
              do_check = (wait_plus >= ugcs_pkg::WAIT_W'(recycle_ms_r));
            end
          end
          ugcs_pkg::PH_RESP: begin
            if (s1_req_r == ugcs_pkg::REQ_IDLE) begin
              do_finish = any_r;
            end else if (s1_req_r == ugcs_pkg::REQ_CHAR) begin
              any_nxt = 1'b1;
              if (is_crlf) begin
                do_finish = (len_r != '0);
              end else begin
                if (s1_char_r == ugcs_pkg::CHAR_NUL) begin
                  nul_nxt = 1'b1;
                end else if (!nul_r && s1_char_r == reject_char_r) begin
                  fail_nxt = 1'b1;
                end
                len_nxt   = len_plus;
                do_finish = (len_plus >= LEN_LAST);
              end
            end
          end
          default: ;
        endcase
      end
      // Ready check after start or recycle: arm, or wait for ready.
      if (do_check) begin
        if (ready_off_r || s1_ready_r) begin
          do_arm = 1'b1;
        end else begin
          wait_nxt = '0;
        end
      end
      // Arming opens a fresh response.
      if (do_arm) begin
        len_nxt  = '0;
        fail_nxt = 1'b0;
        nul_nxt  = 1'b0;
        any_nxt  = 1'b0;
      end
    end
  end

  // Outcome of a finished response: glitched, sweeps exhausted, or still running.
  always_comb begin
    fin_status = ugcs_pkg::ST_RUNNING;
    if (do_finish) begin
      if (!fail_nxt) begin
        fin_status = ugcs_pkg::ST_GLITCHED;
      end else if (delay_plus > delay_top || delay_plus[ugcs_pkg::DELAY_W]) begin
        if (sweep_plus >= retry_limit_r) begin
          fin_status = ugcs_pkg::ST_EXHAUSTED;
        end
      end
    end
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (do_stop) begin
      phase_nxt = ugcs_pkg::PH_IDLE;
    end else if (do_arm) begin
      phase_nxt = ugcs_pkg::PH_RESP;
    end else if (do_check) begin
      phase_nxt = ugcs_pkg::PH_READY;
    end else if (do_finish) begin
      if (fin_status == ugcs_pkg::ST_RUNNING) begin
        phase_nxt = ugcs_pkg::PH_RECYCLE;
      end else begin
        phase_nxt = ugcs_pkg::PH_IDLE;
      end
    end
  end

  // Result word
  always_comb begin
    has_result = do_stop || do_arm || do_finish;
    kind_nxt   = ugcs_pkg::KIND_ARM;
    tx_nxt     = 8'd0;
    pulse_nxt  = '0;
    edges_nxt  = 3'd0;
    gdelay_nxt = delay_r;
    gsweep_nxt = sweep_r;
    rlen_nxt   = '0;
    rfail_nxt  = 1'b0;
    status_nxt = ugcs_pkg::ST_RUNNING;
    if (do_stop) begin
      kind_nxt   = ugcs_pkg::KIND_STOPPED;
      status_nxt = stop_status;
    end else if (do_arm) begin
      tx_nxt     = trigger_char_r;
      pulse_nxt  = pulse_width_r;
      edges_nxt  = ugcs_pkg::runs_of_ones(trigger_char_r);
      gdelay_nxt = delay_nxt;
      gsweep_nxt = sweep_nxt;
    end else if (do_finish) begin
      kind_nxt   = ugcs_pkg::KIND_REPORT;
      rlen_nxt   = len_nxt;
      rfail_nxt  = fail_nxt;
      status_nxt = fin_status;
    end
    out_valid_nxt = out_valid_r && out_stall;
    if (fire) begin
      out_valid_nxt = has_result;
    end
  end

  // Campaign state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ugcs_pkg::PH_IDLE;
      delay_r <= '0;
      sweep_r <= '0;
      wait_r  <= '0;
      len_r   <= '0;
      fail_r  <= 1'b0;
      nul_r   <= 1'b0;
      any_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      wait_r  <= (do_finish && fin_status == ugcs_pkg::ST_RUNNING) ? '0 : wait_nxt;
      len_r   <= len_nxt;
      fail_r  <= fail_nxt;
      nul_r   <= nul_nxt;
      any_r   <= any_nxt;
      if (do_finish && fail_nxt) begin
        if (delay_plus > delay_top || delay_plus[ugcs_pkg::DELAY_W]) begin
          delay_r <= delay_min_r;
          sweep_r <= sweep_plus;
        end else begin
          delay_r <= delay_plus[ugcs_pkg::DELAY_W-1:0];
        end
      end else begin
        delay_r <= delay_nxt;
        sweep_r <= sweep_nxt;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_result) begin
      kind_r   <= kind_nxt;
      tx_r     <= tx_nxt;
      pulse_r  <= pulse_nxt;
      edges_r  <= edges_nxt;
      gdelay_r <= gdelay_nxt;
      gsweep_r <= gsweep_nxt;
      rlen_r   <= rlen_nxt;
      rfail_r  <= rfail_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_kind     = kind_r;
  assign out_tx_char         = tx_r;
  assign out_pulse_on_time   = pulse_r;
  assign out_edge_count      = edges_r;
  assign out_attempt_delay   = gdelay_r;
  assign out_sweep_index     = gsweep_r;
  assign out_response_length = rlen_r;
  assign out_fail_seen       = rfail_r;
  assign out_final_status    = status_r;

  // A stop result always leaves the campaign idle.
  a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && do_stop) |=> (phase_r == ugcs_pkg::PH_IDLE))
    else $error("stop result did not leave the campaign idle");

  // An arm result always opens an empty response.
  a_arm_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && do_arm && !do_stop) |=> (phase_r == ugcs_pkg::PH_RESP && len_r == '0))
    else $error("arm did not open an empty response");

  // The stored length never passes the response limit.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r <= LEN_LAST))
    else $error("stored response length beyond limit");

  // The input only stalls with a word held in the input stage.
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled without a held word");

endmodule
